FILE: rtl/core/smsel_pkg.sv
// ----------------------------------------------------------------------------
// smsel_pkg
// Shared types, sizes and codes for the scatter mechanism selector.
// ----------------------------------------------------------------------------
package smsel_pkg;

	// table geometry
	localparam int NUM_BINS       = 1024;
	localparam int NUM_MECHANISMS = 10;
	localparam int DATA_W         = 32;
	localparam int ADDR_W         = $clog2(NUM_BINS);
	localparam int ROW_W          = NUM_MECHANISMS * DATA_W;

	// fixed field widths of the beats
	localparam int BIN_W  = 10;
	localparam int MECH_W = 4;

	// configuration port
	localparam int PADDR_W = 4;

	// action codes
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_LOAD   = 1'b1;

	// register indexes (word address)
	localparam logic [1:0] REG_MIN_ENERGY  = 2'd0;
	localparam logic [1:0] REG_CEIL_ENERGY = 2'd1;
	localparam logic [1:0] REG_BIN_SCALE   = 2'd2;

	// register reset values
	localparam logic [DATA_W-1:0] RST_MIN_ENERGY  = 32'h0000_0000;
	localparam logic [DATA_W-1:0] RST_CEIL_ENERGY = 32'hFFFF_FFFF;
	localparam logic [DATA_W-1:0] RST_BIN_SCALE   = 32'h0001_0000;

	typedef struct packed {
		logic              action;
		logic [DATA_W-1:0] energy;
		logic [DATA_W-1:0] random_fraction;
		logic [BIN_W-1:0]  load_bin;
		logic [MECH_W-1:0] load_mechanism;
		logic [DATA_W-1:0] load_value;
	} in_beat_t;

	typedef struct packed {
		logic [MECH_W-1:0] mechanism;
		logic [BIN_W-1:0]  bin_index;
	} out_beat_t;

	typedef struct packed {
		logic [DATA_W-1:0] min_energy;
		logic [DATA_W-1:0] ceil_energy;
		logic [DATA_W-1:0] bin_scale;
	} cfg_regs_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SBIN,
		ST_SCMP,
		ST_LRD,
		ST_LWB
	} state_t;

endpackage

FILE: rtl/core/scatter_mechanism_selector_top.sv
// ----------------------------------------------------------------------------
// scatter_mechanism_selector_top
// Inverse-CDF mechanism pick from a table of cumulative probabilities per bin.
// ----------------------------------------------------------------------------
// One item is in flight at a time. A sample beat passes window/offset,
// multiply, clamp, row read and then the compare into the result register
// before the next beat is taken; a load beat goes through accept, row read
// and row write-back and gives no result; a load aimed outside the table is
// dropped at its accept. The pace is set by the read-modify-write of the row
// memory, which holds all mechanism entries of one bin in a row, and by the
// binning pipe in front of it. A result waiting in the output register does
// not hold up the next accept; only the compare of a later sample waits for
// it. The table has no reset and needs no clearing pass: load every entry of
// a bin before sampling it.
// ----------------------------------------------------------------------------
module scatter_mechanism_selector_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// item channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  smsel_pkg::in_beat_t           in_data,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output smsel_pkg::out_beat_t          out_data,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [smsel_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import smsel_pkg::*;

	cfg_regs_t          cfg;
	state_t             state_q, state_next;

	logic               in_acc;
	logic               load_ok;
	logic               bin_start;
	logic               bin_vld;
	logic [ADDR_W-1:0]  bin;

	logic [DATA_W-1:0]  rnd_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [MECH_W-1:0]  col_q;
	logic [DATA_W-1:0]  val_q;
	logic [ADDR_W-1:0]  bin_q;

	logic               ram_re, ram_we;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [ROW_W-1:0]   ram_rdata, ram_wdata;

	logic               out_load;
	logic [MECH_W-1:0]  mech_sel;
	logic               out_valid_q;
	out_beat_t          out_data_q;

	// configuration registers
	smsel_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_acc    = in_valid & in_ready;
	assign load_ok   = (32'(in_data.load_bin) < 32'(NUM_BINS)) &&
	                   (32'(in_data.load_mechanism) < 32'(NUM_MECHANISMS));
	assign bin_start = in_acc && (in_data.action == ACT_SAMPLE);

	// energy binning pipe
	smsel_bin u_bin (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (bin_start),
		.energy  (in_data.energy),
		.cfg     (cfg),
		.bin_vld (bin_vld),
		.bin     (bin)
	);

	// capture the beat
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rnd_q  <= in_data.random_fraction;
			addr_q <= ADDR_W'(in_data.load_bin);
			col_q  <= in_data.load_mechanism;
			val_q  <= in_data.load_value;
		end
		if (state_q == ST_SBIN && bin_vld) begin
			bin_q <= bin;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_data.action == ACT_LOAD) begin
						state_next = load_ok ? ST_LRD : ST_IDLE;
					end else begin
						state_next = ST_SBIN;
					end
				end
			end
			ST_SBIN: begin
				if (bin_vld) state_next = ST_SCMP;
			end
			ST_SCMP: begin
				if (!out_valid_q || out_ready) state_next = ST_IDLE;
			end
			ST_LRD:  state_next = ST_LWB;
			ST_LWB:  state_next = ST_IDLE;
			default: state_next = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready  = 1'b0;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		ram_raddr = addr_q;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_SBIN: begin
				ram_re    = bin_vld;
				ram_raddr = bin;
			end
			ST_SCMP: out_load = !out_valid_q || out_ready;
			ST_LRD:  ram_re = 1'b1;
			ST_LWB:  ram_we = 1'b1;
			default: ;
		endcase
	end

	// merge the loaded entry into the row read back
	always_comb begin
		ram_wdata = ram_rdata;
		ram_wdata[col_q*DATA_W +: DATA_W] = val_q;
	end

	// row memory: one bin per row
	smsel_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NUM_BINS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// first entry above the random value; none above means self-scattering
	always_comb begin
		mech_sel = MECH_W'(NUM_MECHANISMS);
		for (int m = NUM_MECHANISMS - 1; m >= 0; m--) begin
			if (ram_rdata[m*DATA_W +: DATA_W] > rnd_q) begin
				mech_sel = MECH_W'(m);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q.mechanism <= mech_sel;
			out_data_q.bin_index <= BIN_W'(bin_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef ASSERT_OFF
	// a sample beat reaches the end of the binning pipe after the window, multiply and clamp stages
	a_bin_latency: assert property (@(posedge clk) disable iff (!arst_n)
		bin_start |-> ##3 bin_vld)
		else $error("binning result missing three cycles after sample accept");

	// a row write-back always follows its own read
	a_rmw_order: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> $past(ram_re))
		else $error("row written back without a preceding read");

	// no new beat is taken while the row memory is being updated
	a_no_accept_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !in_acc)
		else $error("beat accepted during row write-back");

	// binning pipe only runs while a sample is being worked on
	a_bin_owner: assert property (@(posedge clk) disable iff (!arst_n)
		bin_vld |-> (state_q == ST_SBIN))
		else $error("binning result arrived outside a sample");
`endif

endmodule

FILE: rtl/core/smsel_ram.sv
// ----------------------------------------------------------------------------
// smsel_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module smsel_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/smsel_cfg.sv
// ----------------------------------------------------------------------------
// smsel_cfg
// APB register file holding the energy window and the bin scale.
// ----------------------------------------------------------------------------
module smsel_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [smsel_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output smsel_pkg::cfg_regs_t      cfg
);
	import smsel_pkg::*;

	cfg_regs_t  regs_q;
	logic       wr_en;
	logic [1:0] reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[3:2];
	assign wr_en   = psel & penable & pwrite & pready;
	assign cfg     = regs_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.min_energy  <= RST_MIN_ENERGY;
			regs_q.ceil_energy <= RST_CEIL_ENERGY;
			regs_q.bin_scale   <= RST_BIN_SCALE;
		end else if (wr_en) begin
			case (reg_sel)
				REG_MIN_ENERGY:  regs_q.min_energy  <= pwdata;
				REG_CEIL_ENERGY: regs_q.ceil_energy <= pwdata;
				REG_BIN_SCALE:   regs_q.bin_scale   <= pwdata;
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (reg_sel)
			REG_MIN_ENERGY:  prdata = regs_q.min_energy;
			REG_CEIL_ENERGY: prdata = regs_q.ceil_energy;
			REG_BIN_SCALE:   prdata = regs_q.bin_scale;
			default:         prdata = '0;
		endcase
	end

endmodule

FILE: rtl/core/smsel_bin.sv
// ----------------------------------------------------------------------------
// smsel_bin
// Three-stage energy binning: window test and offset, scale multiply, clamp.
// ----------------------------------------------------------------------------
module smsel_bin (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [smsel_pkg::DATA_W-1:0]    energy,
	input  smsel_pkg::cfg_regs_t            cfg,
	output logic                            bin_vld,
	output logic [smsel_pkg::ADDR_W-1:0]    bin
);
	import smsel_pkg::*;

	localparam int PROD_W = 2 * DATA_W;
	localparam int IDX_W  = PROD_W - 16;

	logic                vld_s1, vld_s2, vld_s3;
	logic                lt_s1, gt_s1, lt_s2, gt_s2;
	logic [DATA_W-1:0]   ofs_s1;
	logic [PROD_W-1:0]   prod_s2;
	logic [ADDR_W-1:0]   bin_s3;
	logic [IDX_W-1:0]    idx;
	logic [ADDR_W-1:0]   bin_next;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// s1: window compare and offset
	always_ff @(posedge clk) begin
		if (start) begin
			lt_s1  <= energy < cfg.min_energy;
			gt_s1  <= energy > cfg.ceil_energy;
			ofs_s1 <= energy - cfg.min_energy;
		end
	end

	// s2: offset times reciprocal bin width
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			lt_s2   <= lt_s1;
			gt_s2   <= gt_s1;
			prod_s2 <= PROD_W'(ofs_s1) * PROD_W'(cfg.bin_scale);
		end
	end

	// s3: drop fraction, clamp below the window to bin 0 and above it to the last bin
	assign idx = prod_s2[PROD_W-1:16];

	always_comb begin
		if (lt_s2) begin
			bin_next = '0;
		end else if (gt_s2 || idx > IDX_W'(NUM_BINS - 1)) begin
			bin_next = ADDR_W'(NUM_BINS - 1);
		end else begin
			bin_next = idx[ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			bin_s3 <= bin_next;
		end
	end

	assign bin_vld = vld_s3;
	assign bin     = bin_s3;

endmodule
